/* rtl/core/vqdm_pkg.sv */
// Package for the virtqueue descriptor manager.
// Holds sizes, opcodes, status codes and the state machine type.
package vqdm_pkg;
  localparam int QUEUE_SIZE = 256;
  localparam int IDX_W = $clog2(QUEUE_SIZE);
  localparam int CNT_W = $clog2(QUEUE_SIZE + 1);
  localparam int DESC_W = 64 + 32 + 1 + 1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_KICK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_LINK_RD,
    S_WALK,
    S_DONE
  } state_t;
endpackage

/* rtl/core/vqdm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module vqdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/virtqueue_descriptor_manager.sv */
// Top level of the virtqueue descriptor manager: control sequencer and tables.
// Depends on vqdm_pkg and vqdm_ram.
//
// Channel  Direction  Contents
// s_axis   in         opcode, seg_addr, seg_len, device_writes, last_segment, ...
// m_axis   out        status, desc_index, head_index, free_count, avail_index, ...
// cfg      in         queue_index
//
// An add or kick passes through accept, link or flag read and result.
// A release also walks the chain between those steps, one descriptor per step,
// as the link and next-flag tables have a registered read.
// After reset an init pass over all QUEUE_SIZE entries writes the link table and
// clears the next flags; no item is taken.
// The result register holds while m_axis_tready is low; no new item is taken then.
module virtqueue_descriptor_manager
  import vqdm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], seg_addr[65:2], seg_len[97:66], device_writes[98],
  // chain_length[107:99], chain_head[115:108], device_no_notify[116], zeros
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], desc_index[9:2], head_index[17:10], free_count[26:18],
  // avail_index[42:27], notify[43], notify_queue[59:44], zeros
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  state_t state, state_next;

  logic [1:0]  op;
  logic [63:0] addr;
  logic [31:0] len;
  logic        devw, last, no_notify;
  logic [8:0]  clen;
  logic [IDX_W-1:0] head;

  logic [IDX_W-1:0] free_head_ptr, open_head, prev_entry, walk_idx, init_idx;
  logic [CNT_W-1:0] free_total, seg_left, walk_n;
  logic [15:0] pending_added, published_avail, queue_index;
  logic chain_open, chain_rejected;

  logic [63:0] out_data;

  logic             link_we, nx_we, desc_we, av_we;
  logic [IDX_W-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic [IDX_W-1:0] nx_waddr, nx_raddr;
  logic             nx_wdata, nx_rdata;
  logic [IDX_W-1:0] av_waddr;

  // Decisions for an add, from registered state.
  logic first_ok, first_rej, add_write, add_post;
  logic [CNT_W-1:0] clen_ext, ft_after, sl_after, close_sum, close_sat;

  vqdm_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_SIZE)) u_link (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata));
  vqdm_ram #(.WIDTH(1), .DEPTH(QUEUE_SIZE)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata));
  logic [DESC_W-1:0] desc_rd;
  vqdm_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_SIZE)) u_desc (
    .clk, .we(desc_we), .waddr(free_head_ptr), .wdata({addr, len, devw, ~last}),
    .raddr(free_head_ptr), .rdata(desc_rd));
  logic [IDX_W-1:0] av_rd;
  vqdm_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_SIZE)) u_avail (
    .clk, .we(av_we), .waddr(av_waddr), .wdata(first_ok ? free_head_ptr : open_head),
    .raddr(av_waddr), .rdata(av_rd));

  always_comb begin
    clen_ext = CNT_W'(clen);
    first_rej = !chain_open && (clen == 9'd0 || {1'b0, clen} > 10'(free_total));
    first_ok = !chain_open && !first_rej;
    ft_after = first_ok ? free_total - clen_ext : free_total;
    sl_after = first_ok ? clen_ext : seg_left;
    add_write = !first_rej && !(chain_open && chain_rejected) && sl_after != '0;
    add_post = !first_rej && !(chain_open && chain_rejected) && last;
    close_sum = ft_after + (add_write ? sl_after - 1'b1 : sl_after);
    close_sat = (close_sum > CNT_W'(QUEUE_SIZE)) ? CNT_W'(QUEUE_SIZE) : close_sum;
  end

  logic [CNT_W:0] rel_sum;
  assign rel_sum = {1'b0, free_total} + {1'b0, walk_n};
  logic [CNT_W-1:0] rel_free;
  assign rel_free = (rel_sum > (CNT_W+1)'(QUEUE_SIZE)) ?
                    CNT_W'(QUEUE_SIZE) : rel_sum[CNT_W-1:0];
  logic walk_stop;
  assign walk_stop = !nx_rdata || walk_n == CNT_W'(QUEUE_SIZE);

  // Result word formed at the end of the table read cycle.
  logic [63:0] link_res;
  always_comb begin
    link_res = '0;
    link_res[26:18] = free_total;
    link_res[42:27] = published_avail;
    unique case (op)
      OP_ADD: begin
        if (first_rej) begin
          link_res[1:0] = ST_NO_SPACE;
        end else begin
          if (chain_open && chain_rejected) begin
            link_res[1:0] = ST_DROPPED;
          end else begin
            link_res[17:10] = first_ok ? free_head_ptr : open_head;
            if (add_write) begin
              link_res[9:2] = free_head_ptr;
            end else begin
              link_res[1:0] = ST_DROPPED;
            end
          end
          link_res[26:18] = last ? close_sat : ft_after;
        end
      end
      OP_KICK: begin
        link_res[42:27] = published_avail + pending_added;
        link_res[43] = !no_notify;
        link_res[59:44] = no_notify ? 16'd0 : queue_index;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    link_we = 1'b0; link_waddr = init_idx; link_wdata = init_idx + 1'b1;
    link_raddr = free_head_ptr;
    nx_we = 1'b0; nx_waddr = free_head_ptr; nx_wdata = ~last; nx_raddr = walk_idx;
    desc_we = 1'b0; av_we = 1'b0;
    av_waddr = IDX_W'(published_avail + pending_added);
    unique case (state)
      S_INIT: begin
        link_we = 1'b1;
        nx_we = 1'b1; nx_waddr = init_idx; nx_wdata = 1'b0;
        if (init_idx == IDX_W'(QUEUE_SIZE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = S_LINK_RD;
      end
      S_LINK_RD: begin
        if (op == OP_RELEASE) begin
          nx_raddr = head;
          link_raddr = head;
          state_next = S_WALK;
        end else begin
          if (op == OP_ADD) begin
            if (add_write) begin
              desc_we = 1'b1; nx_we = 1'b1;
            end else if (add_post) begin
              nx_we = 1'b1; nx_waddr = prev_entry; nx_wdata = 1'b0;
            end
            av_we = add_post;
          end
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          link_we = 1'b1; link_waddr = walk_idx; link_wdata = free_head_ptr;
          state_next = S_DONE;
        end else begin
          link_raddr = link_rdata;
          nx_raddr = link_rdata;
        end
      end
      S_DONE: begin
        if (m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_idx <= '0;
      free_head_ptr <= '0; free_total <= CNT_W'(QUEUE_SIZE);
      seg_left <= '0; pending_added <= '0; published_avail <= '0;
      chain_open <= 1'b0; chain_rejected <= 1'b0;
      open_head <= '0; prev_entry <= '0; queue_index <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) queue_index <= cfg_wdata;
      if (state == S_INIT) init_idx <= init_idx + 1'b1;
      if (state == S_IDLE && s_axis_tvalid) begin
        op <= s_axis_tdata[1:0];
        addr <= s_axis_tdata[65:2];
        len <= s_axis_tdata[97:66];
        devw <= s_axis_tdata[98];
        clen <= s_axis_tdata[107:99];
        head <= s_axis_tdata[115:108];
        no_notify <= s_axis_tdata[116];
        last <= s_axis_tlast;
      end
      if (state == S_LINK_RD) begin
        out_data <= link_res;
        if (op == OP_ADD) begin
          if (first_rej) begin
            if (!last) begin
              chain_open <= 1'b1; chain_rejected <= 1'b1; seg_left <= '0;
            end
          end else begin
            if (first_ok) open_head <= free_head_ptr;
            if (add_write) begin
              free_head_ptr <= link_rdata;
              prev_entry <= free_head_ptr;
            end
            if (add_post) pending_added <= pending_added + 1'b1;
            if (last) begin
              free_total <= close_sat;
              seg_left <= '0; chain_open <= 1'b0; chain_rejected <= 1'b0;
            end else begin
              free_total <= ft_after;
              seg_left <= add_write ? sl_after - 1'b1 : sl_after;
              chain_open <= 1'b1;
              if (first_ok) chain_rejected <= 1'b0;
            end
          end
        end
        if (op == OP_KICK) begin
          published_avail <= published_avail + pending_added;
          pending_added <= '0;
        end
        walk_idx <= head;
        walk_n <= CNT_W'(1);
      end
      if (state == S_WALK) begin
        if (walk_stop) begin
          free_total <= rel_free;
          out_data <= {out_data[63:27], rel_free, head, out_data[9:0]};
          free_head_ptr <= head;
        end else begin
          walk_idx <= link_rdata;
          walk_n <= walk_n + 1'b1;
        end
      end
    end
  end

  assign m_axis_tvalid = (state == S_DONE);
  assign m_axis_tdata = out_data;
endmodule

/* dv/virtqueue_descriptor_manager_checker.sv */
// Checker for the virtqueue descriptor manager: watches both streams and the register port.
// It predicts each result from its own copy of the table state and compares it.
// Depends on vqdm_pkg.
`timescale 1ns / 1ps

module virtqueue_descriptor_manager_checker
  import vqdm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] desc;
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] free;
    logic [15:0]      avail;
    logic             notify;
    logic [15:0]      nq;
  } ring_result_t;

  logic             has_next [QUEUE_SIZE];
  logic [IDX_W-1:0] link [QUEUE_SIZE];
  logic [IDX_W-1:0] free_head;
  logic [IDX_W-1:0] open_head;
  logic [IDX_W-1:0] prev_entry;
  logic [15:0]      added_unpublished;
  logic [15:0]      published;
  logic [15:0]      queue_num;
  int               free_total;
  int               seg_left;
  bit               chain_open;
  bit               chain_rejected;
  ring_result_t     expected_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void close_chain();
    free_total += seg_left;
    if (free_total > QUEUE_SIZE) begin
      free_total = QUEUE_SIZE;
    end
    seg_left = 0;
    chain_open = 0;
    chain_rejected = 0;
  endfunction

  function automatic ring_result_t apply_item(logic [1:0] op, bit last, int clen,
                                              logic [IDX_W-1:0] head, bit no_notify);
    ring_result_t r;
    logic [IDX_W-1:0] i;
    int n;
    bit go;
    r = '0;
    go = 1;
    if (op == OP_ADD) begin
      if (!chain_open) begin
        if (clen == 0 || clen > free_total) begin
          r.status = ST_NO_SPACE;
          go = 0;
          if (!last) begin
            chain_open = 1;
            chain_rejected = 1;
            seg_left = 0;
          end
        end else begin
          free_total -= clen;
          seg_left = clen;
          open_head = free_head;
          chain_open = 1;
          chain_rejected = 0;
        end
      end
      if (go) begin
        if (chain_rejected) begin
          r.status = ST_DROPPED;
          if (last) begin
            close_chain();
          end
        end else if (seg_left == 0) begin
          r.status = ST_DROPPED;
          r.head = open_head;
          if (last) begin
            has_next[prev_entry] = 0;
            added_unpublished++;
            close_chain();
          end
        end else begin
          i = free_head;
          has_next[i] = !last;
          free_head = link[i];
          prev_entry = i;
          seg_left--;
          r.desc = i;
          r.head = open_head;
          if (last) begin
            added_unpublished++;
            close_chain();
          end
        end
      end
    end else if (op == OP_RELEASE) begin
      i = head;
      n = 1;
      while (has_next[i] && n < QUEUE_SIZE) begin
        i = link[i];
        n++;
      end
      free_total += n;
      if (free_total > QUEUE_SIZE) begin
        free_total = QUEUE_SIZE;
      end
      link[i] = free_head;
      free_head = head;
      r.head = head;
    end else if (op == OP_KICK) begin
      published += added_unpublished;
      added_unpublished = 0;
      if (!no_notify) begin
        r.notify = 1;
        r.nq = queue_num;
      end
    end
    r.free = CNT_W'(free_total);
    r.avail = published;
    return r;
  endfunction

  task automatic compare_result(ring_result_t got, ring_result_t want);
    if (got.status != want.status) begin
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    end
    if (got.desc != want.desc) begin
      report($sformatf("desc_index %0d, expected %0d", got.desc, want.desc));
    end
    if (got.head != want.head) begin
      report($sformatf("head_index %0d, expected %0d", got.head, want.head));
    end
    if (got.free != want.free) begin
      report($sformatf("free_count %0d, expected %0d", got.free, want.free));
    end
    if (got.avail != want.avail) begin
      report($sformatf("avail_index %0d, expected %0d", got.avail, want.avail));
    end
    if (got.notify != want.notify) begin
      report($sformatf("notify %0d, expected %0d", got.notify, want.notify));
    end
    if (got.nq != want.nq) begin
      report($sformatf("notify_queue %0h, expected %0h", got.nq, want.nq));
    end
  endtask

  always @(posedge clk) begin
    ring_result_t got;
    if (rst) begin
      for (int k = 0; k < QUEUE_SIZE; k++) begin
        has_next[k] = 0;
        link[k] = IDX_W'(k + 1);
      end
      free_head = '0;
      open_head = '0;
      prev_entry = '0;
      added_unpublished = '0;
      published = '0;
      queue_num = '0;
      free_total = QUEUE_SIZE;
      seg_left = 0;
      chain_open = 0;
      chain_rejected = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        queue_num = cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[17:10],
               m_axis_tdata[26:18], m_axis_tdata[42:27], m_axis_tdata[43],
               m_axis_tdata[59:44]};
        if (expected_results.size() == 0) begin
          report("result transfer with no item outstanding");
        end else begin
          compare_result(got, expected_results.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_item(s_axis_tdata[1:0], s_axis_tlast,
                                              int'(s_axis_tdata[107:99]),
                                              s_axis_tdata[115:108], s_axis_tdata[116]));
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* dv/virtqueue_descriptor_manager_test.sv */
// Top of the descriptor manager testbench: clock, reset, stimulus and verdict.
// Depends on vqdm_pkg, the block and virtqueue_descriptor_manager_checker.
`timescale 1ns / 1ps

module virtqueue_descriptor_manager_test;
  import vqdm_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [1:0] OP_NOP = 2'd3;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  logic         cfg_we = 0;
  logic [15:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  int           stall_left = 0;
  bit           quiet = 0;
  logic [7:0]   known_heads [$];

  always #5 clk = ~clk;

  virtqueue_descriptor_manager i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  virtqueue_descriptor_manager_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("virtqueue_descriptor_manager_test: errors");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the quiet tail of the run.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // Chain heads seen on the result stream feed later releases.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == ST_OK &&
        m_axis_tdata[9:2] == m_axis_tdata[17:10] && m_axis_tdata[17:10] != 0 &&
        known_heads.size() < 64) begin
      known_heads.push_back(m_axis_tdata[17:10]);
    end
  end

  task automatic send(logic [1:0] op, logic [63:0] addr, logic [31:0] len, bit dw,
                      bit last, logic [8:0] clen, logic [7:0] head, bit nn);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {3'b0, nn, head, clen, dw, len, addr, op};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(logic [1:0] op, bit last, logic [8:0] clen, logic [7:0] head);
    send(op, {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)), last, clen, head,
         1'($urandom_range(0, 1)));
  endtask

  task automatic send_chain(int segs, int clen);
    for (int k = 0; k < segs; k++) begin
      send_random(OP_ADD, k == segs - 1, 9'(k == 0 ? clen : $urandom_range(0, 511)),
                  8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_queue_index(logic [15:0] value);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int pick;
    int segs;
    int clen;
    logic [15:0] phase_value [4];
    phase_value = '{16'h0000, 16'hffff, 16'h8001, 16'h0000};
    repeat (2) @(posedge clk);
    rst <= 0;
    write_queue_index(16'hffff);

    send(OP_ADD, '1, '1, 1, 0, 9'd256, '1, 1);
    send(OP_ADD, '0, '0, 0, 1, 9'd0, '0, 0);
    send(OP_KICK, '0, '0, 0, 0, 9'd0, '0, 0);
    send(OP_RELEASE, '0, '0, 0, 0, 9'd0, 8'd0, 0);
    send(OP_ADD, '0, '0, 0, 0, 9'd0, '0, 0);
    send_random(OP_ADD, 0, 9'd3, 8'd0);
    send_random(OP_ADD, 1, 9'd3, 8'd0);
    send(OP_ADD, '1, '1, 1, 1, 9'd511, '1, 1);
    send_chain(2, 3);
    send_chain(3, 1);
    send_chain(2, 2);
    send_random(OP_RELEASE, 0, 9'd0, 8'd5);
    send_random(OP_ADD, 0, 9'd2, 8'd0);
    send_random(OP_RELEASE, 0, 9'd0, 8'd255);
    send_random(OP_ADD, 1, 9'd0, 8'd0);
    send(OP_KICK, '0, '0, 0, 0, 9'd0, '0, 1);
    send(OP_KICK, '1, '1, 1, 1, 9'd511, '1, 0);
    send(OP_NOP, '1, '1, 1, 1, '1, '1, 1);
    send(OP_RELEASE, '1, '1, 1, 1, '1, 8'd3, 1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_queue_index(phase == 2 ? 16'($urandom) : phase_value[phase]);
      for (int n = 0; n < 180; n++) begin
        if (phase == 3 && n >= 110) begin
          quiet = 1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          segs = $urandom_range(1, 6);
          clen = segs;
          if (pick < 5) begin
            clen = segs + $urandom_range(1, 2);
          end else if (pick < 10 && segs > 1) begin
            clen = segs - 1;
          end
          send_chain(segs, clen);
        end else if (pick < 75) begin
          send_random(OP_RELEASE, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                      known_heads.size() > 0 ? known_heads.pop_front() : 8'($urandom));
        end else if (pick < 87) begin
          send_random(OP_KICK, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                      8'($urandom_range(0, 255)));
        end else if (pick < 93) begin
          send_random(OP_ADD, 0, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end else begin
          send_random(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end
      end
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("virtqueue_descriptor_manager_test: clean");
    end else begin
      $display("virtqueue_descriptor_manager_test: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/vqdm_pkg.sv
rtl/core/vqdm_ram.sv
rtl/core/virtqueue_descriptor_manager.sv
dv/virtqueue_descriptor_manager_checker.sv
dv/virtqueue_descriptor_manager_test.sv
